FILE: rtl/tcw_pkg.sv
// shared constants, types and codes of the text console writer
`default_nettype none

package tcw_pkg;

   // screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // internal widths; all but CELL_W derived from the geometry
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int CELL_AW = $clog2(CELLS);
   localparam int CELL_W  = 16;

   // fixed widths of the transaction fields
   localparam int OP_W        = 2;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int COL_FIELD_W = 7;
   localparam int ROW_FIELD_W = 5;
   localparam int POS_FIELD_W = 11;

   // character codes and blank cells
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
   localparam logic [CELL_W-1:0] BLANK_RESET  = {ATTR_RESET, CHAR_SPACE};

   // tab stops
   localparam int TAB_STOP = 4;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_PUT    = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_SETCUR = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CMD_PRINT   = 3'd0,
      CMD_NEWLINE = 3'd1,
      CMD_RETURN  = 3'd2,
      CMD_TAB     = 3'd3,
      CMD_CLEAR   = 3'd4,
      CMD_SETCUR  = 3'd5,
      CMD_READ    = 3'd6
   } cmd_kind_type;

   typedef struct packed {
      op_type                  op;
      logic [CHAR_W-1:0]       char_code;
      logic [COL_FIELD_W-1:0]  col_in;
      logic [ROW_FIELD_W-1:0]  row_in;
      logic [POS_FIELD_W-1:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic [POS_FIELD_W-1:0]  cursor_pos;
      logic [COL_FIELD_W-1:0]  cursor_col;
      logic [ROW_FIELD_W-1:0]  cursor_row;
      logic [CELL_W-1:0]       cell_data;
      logic                    scrolled;
   } rsp_type;

   // classified command as it travels through the queue
   typedef struct packed {
      cmd_kind_type        kind;
      logic [CHAR_W-1:0]   char_code;
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      logic [CELL_AW-1:0]  cell_index;
      logic                index_ok;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/text_console_writer_unit.sv
// top level of the text console writer
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_push / req_full    req_data  (req_type)
// rsp       out        rsp_empty / rsp_pop    rsp_data  (rsp_type)
// csr       in         csr_wr_en              csr_wr_data (text attribute)
//
// put character, set cursor: handled in the engine's idle state; read cell: the data comes
//   from the registered read port of the cell buffer; commands pass through the queue
// scroll: copy sweep of CELLS - COLUMNS cells through the single buffer port pair,
//   then COLUMNS blank writes; clear: a blank write of all CELLS cells
// after reset a blank pass over all CELLS (2000) cells runs with req_full held high
// the command queue keeps taking transactions while the engine sweeps or the
//   result waits; outside the blank pass req_full rises only when the queue
//   holds QUEUE_DEPTH commands

module text_console_writer_unit import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  req_type           req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [ATTR_W-1:0] csr_wr_data
);

   // text attribute register
   logic [ATTR_W-1:0] attr_ff, attr_in;

   // front to queue
   logic    cmd_push;
   cmd_type cmd_push_data;
   logic    queue_full;

   // queue to engine
   logic    cmd_valid;
   cmd_type cmd_head;
   logic    cmd_pop;
   logic    init_busy;

   assign attr_in = csr_wr_en ? csr_wr_data : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // classify each accepted transaction
   tcw_front u_front (
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .queue_full (queue_full),
      .init_busy  (init_busy),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_push_data)
   );

   // decouples the front from long sweeps in the engine
   tcw_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (queue_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .head_data (cmd_head)
   );

   // buffer, cursor and result register
   tcw_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .attr      (attr_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .init_busy (init_busy),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/tcw_front.sv
// front end: takes request transactions and classifies them into commands
`default_nettype none

module tcw_front import tcw_pkg::*; (
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    queue_full,
   input  logic    init_busy,
   output logic    cmd_push,
   output cmd_type cmd_data
);

   always_comb begin
      req_full = queue_full || init_busy;
      cmd_push = req_push && !req_full;
   end

   always_comb begin
      cmd_data           = '0;
      cmd_data.char_code = req_data.char_code;
      // set cursor saturates to the last column and row
      cmd_data.col = (req_data.col_in >= COLUMNS) ? COL_W'(COLUMNS - 1)
                                                  : COL_W'(req_data.col_in);
      cmd_data.row = (req_data.row_in >= ROWS) ? ROW_W'(ROWS - 1)
                                               : ROW_W'(req_data.row_in);
      cmd_data.cell_index = CELL_AW'(req_data.cell_index);
      cmd_data.index_ok   = (req_data.cell_index < CELLS);
      unique case (req_data.op)
         OP_PUT: begin
            priority if (req_data.char_code == CHAR_NEWLINE) cmd_data.kind = CMD_NEWLINE;
            else if (req_data.char_code == CHAR_RETURN)      cmd_data.kind = CMD_RETURN;
            else if (req_data.char_code == CHAR_TAB)         cmd_data.kind = CMD_TAB;
            else                                             cmd_data.kind = CMD_PRINT;
         end
         OP_CLEAR:  cmd_data.kind = CMD_CLEAR;
         OP_SETCUR: cmd_data.kind = CMD_SETCUR;
         OP_READ:   cmd_data.kind = CMD_READ;
         default:   cmd_data.kind = CMD_READ;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/tcw_cmd_queue.sv
// short command queue between the front end and the engine
`default_nettype none

module tcw_cmd_queue import tcw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type head_data
);

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    head_ff, head_in;
   logic [QPTR_W-1:0]    tail_ff, tail_in;
   logic [QCNT_W-1:0]    count_ff, count_in;

   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      valid     = (count_ff != '0);
      head_data = slot_ff[head_ff];
      head_in   = pop  ? head_ff + 1'b1 : head_ff;
      tail_in   = push ? tail_ff + 1'b1 : tail_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue count past depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("command popped from an empty queue");

endmodule

`default_nettype wire

FILE: rtl/tcw_engine.sv
// back end: cell buffer, cursor, scroll and fill sweeps, result register
`default_nettype none

module tcw_engine import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [ATTR_W-1:0] attr,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              init_busy,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rsp_type           rsp_data
);

   typedef enum logic [4:0] {
      S_INIT   = 5'b00001,
      S_IDLE   = 5'b00010,
      S_SCROLL = 5'b00100,
      S_FILL   = 5'b01000,
      S_READ   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     line_ff, line_in;
   logic [CELL_AW-1:0]   cnt_ff, cnt_in;
   logic                 rd_active_ff, rd_active_in;
   logic                 pend_ff, pend_in;
   logic [CELL_AW-1:0]   pend_addr_ff, pend_addr_in;
   logic [CELL_W-1:0]    fill_data_ff, fill_data_in;
   rsp_type              hold_ff, hold_in;
   logic                 res_valid_ff, res_valid_in;
   rsp_type              res_ff, res_in;
   logic                 res_load;

   logic [CELL_W-1:0]    mem [CELLS];
   logic [CELL_W-1:0]    rdata_ff;
   logic                 mem_we;
   logic [CELL_AW-1:0]   mem_waddr;
   logic [CELL_W-1:0]    mem_wdata;
   logic [CELL_AW-1:0]   mem_raddr;

   logic                 slot_free;
   logic [CELL_AW-1:0]   cur_at;
   logic [COL_W:0]       adv_col;
   logic                 line_step;
   logic                 last_line;
   logic [COL_W-1:0]     put_col;
   logic [ROW_W-1:0]     put_line;
   logic                 put_scroll;
   logic [CELL_W-1:0]    blank_cell;

   function automatic rsp_type make_result(input logic [COL_W-1:0]  c,
                                           input logic [ROW_W-1:0]  r,
                                           input logic [CELL_W-1:0] d,
                                           input logic              s);
      rsp_type            res;
      logic [CELL_AW-1:0] pos;
      pos            = CELL_AW'(r) * CELL_AW'(COLUMNS) + CELL_AW'(c);
      res.cursor_pos = POS_FIELD_W'(pos);
      res.cursor_col = COL_FIELD_W'(c);
      res.cursor_row = ROW_FIELD_W'(r);
      res.cell_data  = d;
      res.scrolled   = s;
      return res;
   endfunction

   assign init_busy = (state_ff == S_INIT);
   assign rsp_empty = !res_valid_ff;
   assign rsp_data  = res_ff;
   assign slot_free = !res_valid_ff || rsp_pop;
   assign blank_cell = {attr, CHAR_SPACE};

   // cursor movement of the put commands
   always_comb begin
      cur_at    = CELL_AW'(line_ff) * CELL_AW'(COLUMNS) + CELL_AW'(col_ff);
      adv_col   = (COL_W+1)'(col_ff);
      line_step = 1'b0;
      unique case (cmd.kind)
         CMD_PRINT:   adv_col = (COL_W+1)'(col_ff) + 1'b1;
         CMD_TAB:     adv_col = ((COL_W+1)'(col_ff) + (COL_W+1)'(TAB_STOP))
                                & ~(COL_W+1)'(TAB_STOP - 1);
         CMD_NEWLINE: begin
            adv_col   = '0;
            line_step = 1'b1;
         end
         CMD_RETURN:  adv_col = '0;
         default:     adv_col = (COL_W+1)'(col_ff);
      endcase
      // wrap past the last column
      if (adv_col >= (COL_W+1)'(COLUMNS)) begin
         adv_col   = '0;
         line_step = 1'b1;
      end
      put_col    = COL_W'(adv_col);
      last_line  = (line_ff == ROW_W'(ROWS - 1));
      put_scroll = line_step && last_line;
      put_line   = (line_step && !last_line) ? line_ff + 1'b1 : line_ff;
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      cnt_in       = cnt_ff;
      rd_active_in = rd_active_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      fill_data_in = fill_data_ff;
      hold_in      = hold_ff;
      res_load     = 1'b0;
      res_in       = res_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = fill_data_ff;
      mem_raddr    = cnt_ff + CELL_AW'(COLUMNS);

      unique case (state_ff)
         S_INIT: begin
            // blank pass after reset, always in the reset attribute
            mem_we    = 1'b1;
            mem_wdata = BLANK_RESET;
            if (cnt_ff == CELL_AW'(CELLS - 1)) begin
               state_in = S_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  CMD_PRINT, CMD_NEWLINE, CMD_RETURN, CMD_TAB: begin
                     if (cmd.kind == CMD_PRINT) begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_at;
                        mem_wdata = {attr, cmd.char_code};
                     end
                     col_in  = put_col;
                     line_in = put_line;
                     if (put_scroll) begin
                        state_in     = S_SCROLL;
                        cnt_in       = '0;
                        rd_active_in = 1'b1;
                        pend_in      = 1'b0;
                        fill_data_in = blank_cell;
                        hold_in      = make_result(put_col, put_line, '0, 1'b1);
                     end else begin
                        res_load = 1'b1;
                        res_in   = make_result(put_col, put_line, '0, 1'b0);
                     end
                  end
                  CMD_CLEAR: begin
                     col_in       = '0;
                     line_in      = '0;
                     state_in     = S_FILL;
                     cnt_in       = '0;
                     fill_data_in = blank_cell;
                     hold_in      = make_result('0, '0, '0, 1'b0);
                  end
                  CMD_SETCUR: begin
                     col_in   = cmd.col;
                     line_in  = cmd.row;
                     res_load = 1'b1;
                     res_in   = make_result(cmd.col, cmd.row, '0, 1'b0);
                  end
                  CMD_READ: begin
                     if (cmd.index_ok) begin
                        mem_raddr = cmd.cell_index;
                        state_in  = S_READ;
                        hold_in   = make_result(col_ff, line_ff, '0, 1'b0);
                     end else begin
                        // reads past the buffer give zero
                        res_load = 1'b1;
                        res_in   = make_result(col_ff, line_ff, '0, 1'b0);
                     end
                  end
                  default: begin
                     res_load = 1'b1;
                     res_in   = make_result(col_ff, line_ff, '0, 1'b0);
                  end
               endcase
            end
         end

         S_SCROLL: begin
            // read one row ahead, write back in the cycle after
            if (rd_active_ff) begin
               pend_in      = 1'b1;
               pend_addr_in = cnt_ff;
               if (cnt_ff == CELL_AW'(CELLS - COLUMNS - 1)) begin
                  rd_active_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = rdata_ff;
            end
            if (!rd_active_ff && pend_ff) begin
               // last copy done, blank the bottom row
               state_in = S_FILL;
               cnt_in   = CELL_AW'(CELLS - COLUMNS);
            end
         end

         S_FILL: begin
            mem_we = 1'b1;
            if (cnt_ff == CELL_AW'(CELLS - 1)) begin
               state_in = S_IDLE;
               cnt_in   = '0;
               res_load = 1'b1;
               res_in   = hold_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_READ: begin
            state_in         = S_IDLE;
            res_load         = 1'b1;
            res_in           = hold_ff;
            res_in.cell_data = rdata_ff;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      res_valid_in = res_load || (res_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         col_ff       <= '0;
         line_ff      <= '0;
         cnt_ff       <= '0;
         rd_active_ff <= 1'b0;
         pend_ff      <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         cnt_ff       <= cnt_in;
         rd_active_ff <= rd_active_in;
         pend_ff      <= pend_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      fill_data_ff <= fill_data_in;
      hold_ff      <= hold_in;
      res_ff       <= res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!res_valid_ff || rsp_pop))
      else $error("result register overwritten before it was taken");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff < COL_W'(COLUMNS - 1) || col_ff == COL_W'(COLUMNS - 1)) &&
      (line_ff < ROW_W'(ROWS - 1) || line_ff == ROW_W'(ROWS - 1)))
      else $error("cursor left the screen");

   a_scroll_on_last_row: assert property (@(posedge clock) disable iff (reset)
      (res_load && res_in.scrolled) |->
      (res_in.cursor_row == ROW_FIELD_W'(ROWS - 1) && res_in.cell_data == '0))
      else $error("scroll result not on the last row");

   a_init_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (state_ff == S_INIT && cnt_ff == '0))
      else $error("blank pass did not start after reset");

endmodule

`default_nettype wire
